// ----- rtl/core/tcup_pkg.sv -----
// shared types and constants for the transitive closure core
`default_nettype none

package tcup_pkg;

   localparam int MAX_NODES_DEF = 16;

   localparam int ROW_IDX_W  = 4;
   localparam int ROW_BITS_W = 16;
   localparam int PAIRS_W    = 7;
   localparam int NODE_CNT_W = 5;

   localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 5'd16;
   localparam logic [PAIRS_W-1:0]    PAIRS_MAX    = 7'd127;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_COUNT = 2'd0;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_CLOSE = 5'b00010,
      ST_COUNT = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   // meaning of the row read that returns in the current cycle
   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_PIVOT,
      TAG_CL_ROW,
      TAG_CT_ROW,
      TAG_EM_ROW
   } tag_type;

endpackage

`default_nettype wire

// ----- rtl/core/transitive_closure_unreachable_pairs_core.sv -----
// sequence: rows load first; after the last row comes the closure pass (per pivot a pivot read,
// then a read of every row, written back if it reaches the pivot), then the pair count pass (each
// pivot against the later rows), then the emit pass with one row read in flight, then the flush
// state that ends the run
// throughput: one run at a time, next load accepted while the last result still waits
// reset: node_count back to 16, adjacency store cleared at once through per-row valid bits,
// also cleared after every run; no clearing pass
`default_nettype none

module transitive_closure_unreachable_pairs_core
   import tcup_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [CSR_DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [ROW_IDX_W-1:0]    req_row_index,
   input  wire logic [ROW_BITS_W-1:0]   req_row_bits,
   input  wire logic                    req_last_row,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [ROW_IDX_W-1:0]    rsp_row_index_res,
   output logic      [ROW_BITS_W-1:0]   rsp_reach_bits,
   output logic      [PAIRS_W-1:0]      rsp_unreachable_pairs,
   output logic                         rsp_last
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int XW = ROW_IDX_W + IW;
   localparam int NW = NODE_CNT_W + IW;

   // adjacency store and its read pipeline
   logic [MAX_NODES-1:0] mem_q [MAX_NODES];
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 vld_rd_ff;
   logic                 byp_ff;
   logic [MAX_NODES-1:0] byp_data_ff;
   logic [MAX_NODES-1:0] vld_ff, vld_in;

   logic [IW-1:0]        rd_addr;
   logic                 we;
   logic [IW-1:0]        wa;
   logic [MAX_NODES-1:0] wd;

   state_type            state_ff, state_in;
   tag_type              tag_kind_ff, tag_kind_in;
   logic [IW-1:0]        tag_addr_ff, tag_addr_in;
   logic [IW-1:0]        k_ff, k_in;
   logic [IW-1:0]        i_ff, i_in;
   logic                 piv_issue_ff, piv_issue_in;
   logic [IW-1:0]        nl_ff, nl_in;
   logic [MAX_NODES-1:0] piv_ff, piv_in;
   logic [IW-1:0]        pk_ff, pk_in;
   logic [PAIRS_W-1:0]   pairs_ff, pairs_in;
   logic [NODE_CNT_W-1:0] node_count_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [ROW_BITS_W-1:0] rsp_bits_ff, rsp_bits_in;
   logic [PAIRS_W-1:0]    rsp_pairs_ff, rsp_pairs_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                        req_fire;
   logic [XW-1:0]               req_idx_ext;
   logic                        idx_ok;
   logic [MAX_NODES+ROW_BITS_W-1:0] req_bits_ext;
   logic [MAX_NODES-1:0]        req_bits;
   logic [NW-1:0]               nc_ext, nc_m1;
   logic [IW-1:0]               nl_new;
   logic [MAX_NODES-1:0]        mask;
   logic [MAX_NODES-1:0]        raw, val;
   logic [IW+ROW_IDX_W-1:0]     em_idx_ext;
   logic [MAX_NODES+ROW_BITS_W-1:0] em_val_ext;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_NODE_COUNT) ?
                       {{(CSR_DATA_W-NODE_CNT_W){1'b0}}, node_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_CNT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_NODE_COUNT)) begin
         node_count_ff <= csr_pwdata[NODE_CNT_W-1:0];
      end
   end

   // input decode
   assign req_ready    = (state_ff == ST_LOAD);
   assign req_fire     = req_valid && req_ready;
   assign req_idx_ext  = {{IW{1'b0}}, req_row_index};
   assign idx_ok       = (req_idx_ext < XW'(MAX_NODES));
   assign req_bits_ext = {{MAX_NODES{1'b0}}, req_row_bits};
   assign req_bits     = req_bits_ext[MAX_NODES-1:0];

   // effective node count, kept as its last index
   assign nc_ext = {{IW{1'b0}}, node_count_ff};
   assign nc_m1  = nc_ext - NW'(1);
   always_comb begin
      if (nc_ext == '0) begin
         nl_new = '0;
      end else if (nc_ext > NW'(MAX_NODES)) begin
         nl_new = IW'(MAX_NODES - 1);
      end else begin
         nl_new = nc_m1[IW-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_NODES; j++) begin
         mask[j] = (IW'(j) <= nl_ff);
      end
   end

   // returning row: forwarded write, else stored data if the row is valid
   assign raw = byp_ff ? byp_data_ff : (vld_rd_ff ? rd_data_ff : '0);
   assign val = raw & mask;

   assign em_idx_ext = {{ROW_IDX_W{1'b0}}, tag_addr_ff};
   assign em_val_ext = {{ROW_BITS_W{1'b0}}, val};

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      piv_issue_in = piv_issue_ff;
      nl_in        = nl_ff;
      piv_in       = piv_ff;
      pk_in        = pk_ff;
      pairs_in     = pairs_ff;
      vld_in       = vld_ff;
      tag_kind_in  = TAG_NONE;
      tag_addr_in  = '0;
      rd_addr      = '0;
      we           = 1'b0;
      wa           = '0;
      wd           = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_pairs_in = rsp_pairs_ff;
      rsp_last_in  = rsp_last_ff;

      // data issued last cycle
      case (tag_kind_ff)
         TAG_NONE: begin
         end
         TAG_PIVOT: begin
            piv_in = val;
            pk_in  = tag_addr_ff;
         end
         TAG_CL_ROW: begin
            if (val[pk_ff]) begin
               we = 1'b1;
               wa = tag_addr_ff;
               wd = val | piv_ff;
            end
         end
         TAG_CT_ROW: begin
            if (!piv_ff[tag_addr_ff] && !val[pk_ff] && (pairs_ff != PAIRS_MAX)) begin
               pairs_in = pairs_ff + PAIRS_W'(1);
            end
         end
         TAG_EM_ROW: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = em_idx_ext[ROW_IDX_W-1:0];
            rsp_bits_in  = em_val_ext[ROW_BITS_W-1:0];
            rsp_pairs_in = pairs_ff;
            rsp_last_in  = (tag_addr_ff == nl_ff);
         end
         default: begin
         end
      endcase

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (idx_ok) begin
                  we = 1'b1;
                  wa = req_idx_ext[IW-1:0];
                  wd = req_bits;
               end
               if (req_last_row) begin
                  state_in     = ST_CLOSE;
                  k_in         = '0;
                  piv_issue_in = 1'b1;
                  nl_in        = nl_new;
                  pairs_in     = '0;
               end
            end
         end
         ST_CLOSE: begin
            if (piv_issue_ff) begin
               rd_addr      = k_ff;
               tag_kind_in  = TAG_PIVOT;
               tag_addr_in  = k_ff;
               piv_issue_in = 1'b0;
               i_in         = '0;
            end else begin
               rd_addr     = i_ff;
               tag_kind_in = TAG_CL_ROW;
               tag_addr_in = i_ff;
               if (i_ff == nl_ff) begin
                  piv_issue_in = 1'b1;
                  if (k_ff == nl_ff) begin
                     state_in = ST_COUNT;
                     k_in     = '0;
                  end else begin
                     k_in = k_ff + IW'(1);
                  end
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         ST_COUNT: begin
            // pivot p against rows p+1 .. n-1
            if (nl_ff == '0) begin
               state_in = ST_EMIT;
               i_in     = '0;
            end else if (piv_issue_ff) begin
               rd_addr      = k_ff;
               tag_kind_in  = TAG_PIVOT;
               tag_addr_in  = k_ff;
               piv_issue_in = 1'b0;
               i_in         = k_ff + IW'(1);
            end else begin
               rd_addr     = i_ff;
               tag_kind_in = TAG_CT_ROW;
               tag_addr_in = i_ff;
               if (i_ff == nl_ff) begin
                  if (k_ff == nl_ff - IW'(1)) begin
                     state_in = ST_EMIT;
                     i_in     = '0;
                  end else begin
                     k_in         = k_ff + IW'(1);
                     piv_issue_in = 1'b1;
                  end
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         ST_EMIT: begin
            // one read in flight, issued only when the output register frees up
            if ((tag_kind_ff != TAG_EM_ROW) && (!rsp_valid_ff || rsp_ready)) begin
               rd_addr     = i_ff;
               tag_kind_in = TAG_EM_ROW;
               tag_addr_in = i_ff;
               if (i_ff == nl_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end
         end
         ST_FLUSH: begin
            vld_in   = '0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (we) begin
         vld_in[wa] = 1'b1;
      end
   end

   // row memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem_q[wa] <= wd;
      end
      rd_data_ff <= mem_q[rd_addr];
   end

   always_ff @(posedge clock) begin
      vld_rd_ff    <= vld_ff[rd_addr];
      byp_ff       <= we && (wa == rd_addr);
      byp_data_ff  <= wd;
      tag_addr_ff  <= tag_addr_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      nl_ff        <= nl_in;
      piv_ff       <= piv_in;
      pk_ff        <= pk_in;
      pairs_ff     <= pairs_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_pairs_ff <= rsp_pairs_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         tag_kind_ff  <= TAG_NONE;
         piv_issue_ff <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_kind_ff  <= tag_kind_in;
         piv_issue_ff <= piv_issue_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_row_index_res     = rsp_idx_ff;
   assign rsp_reach_bits        = rsp_bits_ff;
   assign rsp_unreachable_pairs = rsp_pairs_ff;
   assign rsp_last              = rsp_last_ff;

endmodule

`default_nettype wire
